/* sv/ulbd_pkg.sv */
`timescale 1ns / 1ps

package ulbd_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned HELD_DEPTH  = 3;

    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] RAW_MIN   = 8'hF8;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  bytes_used;
        logic        last_of_run;
    } ulbd_result_t;

    // All results caused by one input byte, in delivery order from entry 0.
    typedef struct packed {
        ulbd_result_t [MAX_RESULTS-1:0] res;
        logic [2:0]                     count;
    } ulbd_batch_t;

endpackage

/* sv/ulbd_core.sv */
`timescale 1ns / 1ps

module ulbd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         in_byte,
    input  logic               end_of_string,
    output ulbd_pkg::ulbd_batch_t batch
);
    import ulbd_pkg::*;

    logic [7:0] held_reg [HELD_DEPTH];
    logic [7:0] held_next [HELD_DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] exp_reg, exp_next;

    logic        is_cont;
    logic        is_lead;
    logic        seq_open;
    logic        complete;
    logic        emit_b;
    logic [2:0]  flush_cnt;
    logic [2:0]  n_res;
    logic [2:0]  lead_len;
    logic [20:0] decoded;

    always_comb
    begin
        is_cont  = (in_byte[7:6] == CONT_TAG);
        is_lead  = (in_byte >= LEAD2_MIN) && (in_byte < RAW_MIN);
        seq_open = (exp_reg != 3'd0);
        complete = ({1'b0, cnt_reg} + 3'd1) >= exp_reg;
        lead_len = (in_byte < LEAD3_MIN) ? 3'd2 : ((in_byte < LEAD4_MIN) ? 3'd3 : 3'd4);

        case (exp_reg)
            3'd2:    decoded = {10'd0, held_reg[0][4:0], in_byte[5:0]};
            3'd3:    decoded = {5'd0, held_reg[0][3:0], held_reg[1][5:0], in_byte[5:0]};
            default: decoded = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                                in_byte[5:0]};
        endcase

        // Held bytes go out raw when the sequence breaks or the string ends early.
        if (seq_open && (!is_cont || (!complete && end_of_string)))
            flush_cnt = {1'b0, cnt_reg};
        else
            flush_cnt = 3'd0;

        if (seq_open && is_cont)
            emit_b = !complete && end_of_string;
        else
            emit_b = !is_lead || end_of_string;

        n_res = flush_cnt + {2'b00, emit_b};

        batch = '0;
        if (seq_open && is_cont && complete)
        begin
            batch.count                 = 3'd1;
            batch.res[0].code_point     = decoded;
            batch.res[0].bytes_used     = exp_reg;
            batch.res[0].last_of_run    = 1'b1;
        end
        else
        begin
            batch.count = n_res;
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                batch.res[k].code_point  = {13'd0, in_byte};
                batch.res[k].bytes_used  = 3'd1;
                batch.res[k].last_of_run = (3'(k) == n_res - 3'd1);
            end
            for (int k = 0; k < HELD_DEPTH; k++)
            begin
                if (3'(k) < flush_cnt)
                    batch.res[k].code_point = {13'd0, held_reg[k]};
            end
        end

        held_next = held_reg;
        cnt_next  = cnt_reg;
        exp_next  = exp_reg;
        if (fire)
        begin
            if (seq_open && is_cont)
            begin
                if (complete || end_of_string)
                begin
                    cnt_next = 2'd0;
                    exp_next = 3'd0;
                end
                else
                begin
                    for (int k = 0; k < HELD_DEPTH; k++)
                    begin
                        if (2'(k) == cnt_reg)
                            held_next[k] = in_byte;
                    end
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            else if (is_lead && !end_of_string)
            begin
                held_next[0] = in_byte;
                cnt_next     = 2'd1;
                exp_next     = lead_len;
            end
            else
            begin
                cnt_next = 2'd0;
                exp_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            exp_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            exp_reg <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

/* sv/ulbd_outq.sv */
`timescale 1ns / 1ps

module ulbd_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  ulbd_pkg::ulbd_batch_t batch,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ulbd_pkg::ulbd_result_t head
);
    import ulbd_pkg::*;

    ulbd_result_t q_reg [MAX_RESULTS];
    ulbd_result_t q_next [MAX_RESULTS];
    logic [2:0]   cnt_reg, cnt_next;
    logic         pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    // A new batch may land in the same cycle the last pending result transfers.
    assign free      = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && pop);
    assign head      = q_reg[0];

    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            for (int k = 0; k < MAX_RESULTS; k++)
                q_next[k] = batch.res[k];
            cnt_next = batch.count;
        end
        else if (pop)
        begin
            for (int k = 0; k < MAX_RESULTS - 1; k++)
                q_next[k] = q_reg[k+1];
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

/* sv/utf8_lenient_byte_decoder.sv */
`timescale 1ns / 1ps
// A byte is registered in the input register, then its results in the output queue,
// whose head drives the output; a busy queue holds the byte in the input register.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_ready is high; a byte with several results holds the queue until all transfer.
// Reset (rst_n, asynchronous, active low) empties the input register and the output
// queue and leaves the decoder with no open sequence.

module utf8_lenient_byte_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic [2:0]  bytes_used,
    output logic        last_of_run
);
    import ulbd_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   byte_reg;
    logic         eos_reg;
    logic         free;
    logic         advance;
    ulbd_batch_t  batch;
    ulbd_result_t head;

    assign advance  = in_valid_reg && free;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            eos_reg  <= end_of_string;
        end
    end

    ulbd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .in_byte       (byte_reg),
        .end_of_string (eos_reg),
        .batch         (batch)
    );

    ulbd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .batch     (batch),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign code_point  = head.code_point;
    assign bytes_used  = head.bytes_used;
    assign last_of_run = head.last_of_run;

    // A decoded multi-byte sequence is always the only result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (bytes_used != 3'd1) |-> last_of_run)
        else $error("decoded result not marked last");

    // Raw results carry a single byte value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (bytes_used == 3'd1) |-> (code_point[20:8] == 13'd0))
        else $error("raw result wider than a byte");

    // A registered byte that cannot move on is kept.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !free |=> in_valid_reg)
        else $error("registered input byte lost");

    // A byte leaves the input register only into a free output queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_valid_reg) |-> $past(free))
        else $error("input byte dropped while queue busy");

endmodule
